// ===== rtl/skrp_pkg.sv =====
// ----------------------------------------------------------------------------
// skrp_pkg
// Shared types and constants for the skyline rectangle packer.
// ----------------------------------------------------------------------------
`default_nettype none

package skrp_pkg;

  localparam int CFG_W     = 13;
  localparam int DIM_W     = 12;
  localparam int POS_W     = 12;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_MAX_SEGMENTS = 1024;
  localparam int DEF_COORD_BITS   = 12;

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 13'd512;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOFIT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  localparam logic OP_RESERVE = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'd1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR,
    ST_SRD,
    ST_SEV,
    ST_DEC,
    ST_BRD,
    ST_BEV,
    ST_BEND,
    ST_OUT
  } state_t;

  // Control of the two-bank segment table.
  typedef struct packed {
    logic wr_en;
    logic wr_bank;
    logic rd_bank;
  } tbl_ctl_t;

endpackage : skrp_pkg

`default_nettype wire

// ===== rtl/skrp_if.sv =====
// ----------------------------------------------------------------------------
// skrp_if
// Handshake channels of the skyline rectangle packer.
// ----------------------------------------------------------------------------
`default_nettype none

interface skrp_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [skrp_pkg::DIM_W-1:0]   rect_width;
  logic [skrp_pkg::DIM_W-1:0]   rect_height;
  modport source (output valid, opcode, rect_width, rect_height, input ready);
  modport sink (input valid, opcode, rect_width, rect_height, output ready);
endinterface : skrp_in_if

interface skrp_out_if;
  logic                         valid;
  logic                         ready;
  logic [skrp_pkg::STAT_W-1:0]  status;
  logic [skrp_pkg::POS_W-1:0]   pos_x;
  logic [skrp_pkg::POS_W-1:0]   pos_y;
  modport source (output valid, status, pos_x, pos_y, input ready);
  modport sink (input valid, status, pos_x, pos_y, output ready);
endinterface : skrp_out_if

interface skrp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [skrp_pkg::CFG_IDX_W-1:0] index;
  logic [skrp_pkg::CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface : skrp_cfg_if

`default_nettype wire

// ===== rtl/skrp_seg_table.sv =====
// ----------------------------------------------------------------------------
// skrp_seg_table
// Two banks of segment storage; one bank is read while the other is rebuilt.
// ----------------------------------------------------------------------------
`default_nettype none

module skrp_seg_table #(
  parameter int NUM_ENTRIES = skrp_pkg::DEF_MAX_SEGMENTS,
  parameter int ENTRY_W     = 3 * skrp_pkg::DEF_COORD_BITS
) (
  input  wire logic                           clk,
  input  wire skrp_pkg::tbl_ctl_t             ctl,
  input  wire logic [$clog2(NUM_ENTRIES)-1:0] rd_addr,
  output logic      [ENTRY_W-1:0]             rd_data,
  input  wire logic [$clog2(NUM_ENTRIES)-1:0] wr_addr,
  input  wire logic [ENTRY_W-1:0]             wr_data
);

  logic [ENTRY_W-1:0] bank0_mem [NUM_ENTRIES];
  logic [ENTRY_W-1:0] bank1_mem [NUM_ENTRIES];
  logic [ENTRY_W-1:0] q0_r;
  logic [ENTRY_W-1:0] q1_r;
  logic               sel_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en && !ctl.wr_bank) begin
      bank0_mem[wr_addr] <= wr_data;
    end
    q0_r <= bank0_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en && ctl.wr_bank) begin
      bank1_mem[wr_addr] <= wr_data;
    end
    q1_r <= bank1_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    sel_r <= ctl.rd_bank;
  end

  assign rd_data = sel_r ? q1_r : q0_r;

endmodule : skrp_seg_table

`default_nettype wire

// ===== rtl/skyline_rect_packer.sv =====
// ----------------------------------------------------------------------------
// skyline_rect_packer
// Skyline bottom-left rectangle packer with a two-bank segment table.
// ----------------------------------------------------------------------------
// A clear writes the initial segment anew; a zero-sized request goes straight
// to the output with no-fit status. A reserve runs a fit walk from each start
// segment, then a rebuild pass into the other bank; with no fit or a full
// table it skips the rebuild. One item at a time; the single table read port
// and its registered data mean each visited segment is read, then evaluated.
// After reset the block writes the initial segment before it takes an item;
// configuration writes are taken at any time.
`default_nettype none

module skyline_rect_packer #(
  parameter int MAX_SEGMENTS = skrp_pkg::DEF_MAX_SEGMENTS,
  parameter int COORD_BITS   = skrp_pkg::DEF_COORD_BITS
) (
  input wire logic clk,
  input wire logic rst_n,
  skrp_cfg_if.sink   cfg_ch,
  skrp_in_if.sink    in_ch,
  skrp_out_if.source out_ch
);

  localparam int CB   = COORD_BITS;
  localparam int SW   = ((CB > skrp_pkg::DIM_W) ? CB : skrp_pkg::DIM_W) + 3;
  localparam int IW   = $clog2(MAX_SEGMENTS);
  localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
  localparam int EW   = 3 * CB;

  localparam logic [SW-1:0]   LIM     = SW'(1) << CB;
  localparam logic [SW-1:0]   MASK    = LIM - SW'(1);
  localparam logic [SW-1:0]   MIN_DIM = SW'(4);
  localparam logic [SW-1:0]   ONE     = SW'(1);
  localparam logic [SW-1:0]   TWO     = SW'(2);
  localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_SEGMENTS);
  localparam logic [CNTW-1:0] CNT_ONE = CNTW'(1);

  skrp_pkg::state_t state_r, state_nxt;

  logic [skrp_pkg::CFG_W-1:0] aw_cfg_r, ah_cfg_r;
  logic [SW-1:0] aw_ext, ah_ext, aw_eff, ah_eff;

  logic            bank_r, bank_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [SW-1:0]   rw_r, rw_nxt, rh_r, rh_nxt;
  logic [CNTW-1:0] start_r, start_nxt, idx_r, idx_nxt;
  logic [SW-1:0]   t_r, t_nxt, remain_r, remain_nxt;
  logic [SW-1:0]   cand_x_r, cand_x_nxt, cand_w_r, cand_w_nxt;
  logic            found_r, found_nxt;
  logic [CNTW-1:0] best_r, best_nxt;
  logic [SW-1:0]   best_top_r, best_top_nxt, best_w_r, best_w_nxt;
  logic [SW-1:0]   bx_r, bx_nxt, by_r, by_nxt;
  logic [CNTW-1:0] j_r, j_nxt, wr_ptr_r, wr_ptr_nxt;
  logic            n_done_r, n_done_nxt, trim_r, trim_nxt, acc_v_r, acc_v_nxt;
  logic [SW-1:0]   acc_x_r, acc_x_nxt, acc_y_r, acc_y_nxt, acc_w_r, acc_w_nxt;

  logic [skrp_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic [skrp_pkg::POS_W-1:0]  res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [skrp_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [skrp_pkg::POS_W-1:0]  out_x_r, out_x_nxt, out_y_r, out_y_nxt;

  skrp_pkg::tbl_ctl_t tbl_ctl;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] rd_data, wr_data;

  logic          in_xfer, zero_req, out_free;
  logic [SW-1:0] d_x, d_y, d_w;
  logic          first, x_over, h_over, done_walk, better;
  logic          walk_fail, walk_ok, last_idx, next_start, start_last;
  logic [SW-1:0] t_new, key, cur_w, cur_x;
  logic [CNTW-1:0] start_inc, idx_inc, j_inc;
  logic          emit_n, e_v, trim_clr, merge_hit;
  logic [SW-1:0] e_x, e_y, e_w, nend, d_end;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_cfg_r <= skrp_pkg::CFG_DIM_RESET;
      ah_cfg_r <= skrp_pkg::CFG_DIM_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        skrp_pkg::CFG_IDX_WIDTH:  aw_cfg_r <= cfg_ch.data;
        skrp_pkg::CFG_IDX_HEIGHT: ah_cfg_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign aw_ext = SW'(aw_cfg_r);
  assign ah_ext = SW'(ah_cfg_r);
  assign aw_eff = (aw_ext < MIN_DIM) ? MIN_DIM : ((aw_ext > LIM) ? LIM : aw_ext);
  assign ah_eff = (ah_ext < MIN_DIM) ? MIN_DIM : ((ah_ext > LIM) ? LIM : ah_ext);

  // --------------------------------------------------------------------------
  // Segment table
  // --------------------------------------------------------------------------
  skrp_seg_table #(
    .NUM_ENTRIES (MAX_SEGMENTS),
    .ENTRY_W     (EW)
  ) u_table (
    .clk     (clk),
    .ctl     (tbl_ctl),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign d_x = SW'(rd_data[3*CB-1:2*CB]);
  assign d_y = SW'(rd_data[2*CB-1:CB]);
  assign d_w = SW'(rd_data[CB-1:0]);

  // --------------------------------------------------------------------------
  // Decisions shared by the sequencer blocks
  // --------------------------------------------------------------------------
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign zero_req = (in_ch.rect_width == '0) || (in_ch.rect_height == '0);
  assign out_free = !out_valid_r || out_ch.ready;

  // Fit walk step.
  assign first      = (idx_r == start_r);
  assign x_over     = (d_x + rw_r) >= aw_eff;
  assign t_new      = (d_y > t_r) ? d_y : t_r;
  assign key        = t_new + rh_r;
  assign h_over     = key >= ah_eff;
  assign done_walk  = d_w >= remain_r;
  assign cur_w      = first ? d_w : cand_w_r;
  assign cur_x      = first ? d_x : cand_x_r;
  assign better     = !found_r || (key < best_top_r) ||
                      ((key == best_top_r) && (cur_w < best_w_r));
  assign walk_fail  = (first && x_over) || h_over;
  assign walk_ok    = !walk_fail && done_walk;
  assign idx_inc    = idx_r + CNT_ONE;
  assign start_inc  = start_r + CNT_ONE;
  assign last_idx   = idx_inc >= count_r;
  assign next_start = walk_fail || walk_ok || last_idx;
  assign start_last = start_inc >= count_r;

  // Rebuild step: the new segment goes in ahead of the old best entry, the
  // segments it covers are trimmed or dropped, and equal heights merge.
  assign nend   = bx_r + rw_r;
  assign d_end  = d_x + d_w;
  assign j_inc  = j_r + CNT_ONE;
  assign emit_n = !n_done_r && (j_r == best_r);

  always_comb begin
    e_v      = 1'b1;
    e_x      = d_x;
    e_y      = d_y;
    e_w      = d_w;
    trim_clr = 1'b0;
    if (emit_n) begin
      e_x = bx_r;
      e_y = by_r + rh_r;
      e_w = rw_r;
    end else if (trim_r) begin
      if (d_x < nend) begin
        if (d_end > nend) begin
          e_x      = nend;
          e_w      = d_end - nend;
          trim_clr = 1'b1;
        end else begin
          e_v = 1'b0;
        end
      end else begin
        trim_clr = 1'b1;
      end
    end
  end

  assign merge_hit = acc_v_r && (acc_y_r == e_y);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      skrp_pkg::ST_INIT: state_nxt = skrp_pkg::ST_IDLE;
      skrp_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_ch.opcode == skrp_pkg::OP_CLEAR) begin
            state_nxt = skrp_pkg::ST_CLR;
          end else if (zero_req) begin
            state_nxt = skrp_pkg::ST_OUT;
          end else begin
            state_nxt = skrp_pkg::ST_SRD;
          end
        end
      end
      skrp_pkg::ST_CLR: state_nxt = skrp_pkg::ST_OUT;
      skrp_pkg::ST_SRD: state_nxt = skrp_pkg::ST_SEV;
      skrp_pkg::ST_SEV: begin
        if (next_start && start_last) begin
          state_nxt = skrp_pkg::ST_DEC;
        end else begin
          state_nxt = skrp_pkg::ST_SRD;
        end
      end
      skrp_pkg::ST_DEC: begin
        if (!found_r || (count_r >= CNT_MAX)) begin
          state_nxt = skrp_pkg::ST_OUT;
        end else begin
          state_nxt = skrp_pkg::ST_BRD;
        end
      end
      skrp_pkg::ST_BRD: state_nxt = skrp_pkg::ST_BEV;
      skrp_pkg::ST_BEV: begin
        if (emit_n) begin
          state_nxt = skrp_pkg::ST_BEV;
        end else if (j_inc >= count_r) begin
          state_nxt = skrp_pkg::ST_BEND;
        end else begin
          state_nxt = skrp_pkg::ST_BRD;
        end
      end
      skrp_pkg::ST_BEND: state_nxt = skrp_pkg::ST_OUT;
      skrp_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = skrp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = skrp_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and table controls
  // --------------------------------------------------------------------------
  always_comb begin
    bank_nxt       = bank_r;
    count_nxt      = count_r;
    rw_nxt         = rw_r;
    rh_nxt         = rh_r;
    start_nxt      = start_r;
    idx_nxt        = idx_r;
    t_nxt          = t_r;
    remain_nxt     = remain_r;
    cand_x_nxt     = cand_x_r;
    cand_w_nxt     = cand_w_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_top_nxt   = best_top_r;
    best_w_nxt     = best_w_r;
    bx_nxt         = bx_r;
    by_nxt         = by_r;
    j_nxt          = j_r;
    wr_ptr_nxt     = wr_ptr_r;
    n_done_nxt     = n_done_r;
    trim_nxt       = trim_r;
    acc_v_nxt      = acc_v_r;
    acc_x_nxt      = acc_x_r;
    acc_y_nxt      = acc_y_r;
    acc_w_nxt      = acc_w_r;
    res_status_nxt = res_status_r;
    res_x_nxt      = res_x_r;
    res_y_nxt      = res_y_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    tbl_ctl.wr_en   = 1'b0;
    tbl_ctl.wr_bank = bank_r;
    tbl_ctl.rd_bank = bank_r;
    rd_addr = idx_r[IW-1:0];
    wr_addr = '0;
    wr_data = {CB'(ONE), CB'(ONE), CB'(aw_eff - TWO)};

    unique case (state_r)
      skrp_pkg::ST_INIT: begin
        tbl_ctl.wr_en = 1'b1;
        count_nxt     = CNT_ONE;
      end
      skrp_pkg::ST_IDLE: begin
        if (in_xfer) begin
          rw_nxt         = SW'(in_ch.rect_width);
          rh_nxt         = SW'(in_ch.rect_height);
          start_nxt      = '0;
          idx_nxt        = '0;
          t_nxt          = '0;
          remain_nxt     = SW'(in_ch.rect_width);
          found_nxt      = 1'b0;
          res_status_nxt = zero_req ? skrp_pkg::STAT_NOFIT : skrp_pkg::STAT_OK;
          res_x_nxt      = '0;
          res_y_nxt      = '0;
        end
      end
      skrp_pkg::ST_CLR: begin
        tbl_ctl.wr_en  = 1'b1;
        count_nxt      = CNT_ONE;
        res_status_nxt = skrp_pkg::STAT_OK;
      end
      skrp_pkg::ST_SRD: begin
        rd_addr = idx_r[IW-1:0];
      end
      skrp_pkg::ST_SEV: begin
        if (first) begin
          cand_x_nxt = d_x;
          cand_w_nxt = d_w;
        end
        if (walk_ok && better) begin
          found_nxt    = 1'b1;
          best_nxt     = start_r;
          best_top_nxt = key;
          best_w_nxt   = cur_w;
          bx_nxt       = cur_x;
          by_nxt       = t_new;
        end
        if (next_start) begin
          start_nxt  = start_inc;
          idx_nxt    = start_inc;
          t_nxt      = '0;
          remain_nxt = rw_r;
        end else begin
          idx_nxt    = idx_inc;
          t_nxt      = t_new;
          remain_nxt = remain_r - d_w;
        end
      end
      skrp_pkg::ST_DEC: begin
        j_nxt      = '0;
        wr_ptr_nxt = '0;
        n_done_nxt = 1'b0;
        trim_nxt   = 1'b0;
        acc_v_nxt  = 1'b0;
        if (!found_r) begin
          res_status_nxt = skrp_pkg::STAT_NOFIT;
        end else if (count_r >= CNT_MAX) begin
          res_status_nxt = skrp_pkg::STAT_FULL;
        end
      end
      skrp_pkg::ST_BRD: begin
        rd_addr = j_r[IW-1:0];
      end
      skrp_pkg::ST_BEV: begin
        rd_addr         = j_r[IW-1:0];
        tbl_ctl.wr_bank = !bank_r;
        wr_addr         = wr_ptr_r[IW-1:0];
        wr_data         = {acc_x_r[CB-1:0], acc_y_r[CB-1:0], acc_w_r[CB-1:0]};
        if (emit_n) begin
          n_done_nxt = 1'b1;
          trim_nxt   = 1'b1;
        end else begin
          j_nxt = j_inc;
          if (trim_clr) begin
            trim_nxt = 1'b0;
          end
        end
        if (e_v) begin
          if (merge_hit) begin
            acc_w_nxt = acc_w_r + e_w;
          end else begin
            // The held segment is final once a different height follows.
            if (acc_v_r) begin
              tbl_ctl.wr_en = 1'b1;
              wr_ptr_nxt    = wr_ptr_r + CNT_ONE;
            end
            acc_v_nxt = 1'b1;
            acc_x_nxt = e_x;
            acc_y_nxt = e_y;
            acc_w_nxt = e_w;
          end
        end
      end
      skrp_pkg::ST_BEND: begin
        tbl_ctl.wr_en   = 1'b1;
        tbl_ctl.wr_bank = !bank_r;
        wr_addr         = wr_ptr_r[IW-1:0];
        wr_data         = {acc_x_r[CB-1:0], acc_y_r[CB-1:0], acc_w_r[CB-1:0]};
        count_nxt       = wr_ptr_r + CNT_ONE;
        bank_nxt        = !bank_r;
        res_status_nxt  = skrp_pkg::STAT_OK;
        res_x_nxt       = skrp_pkg::POS_W'(bx_r & MASK);
        res_y_nxt       = skrp_pkg::POS_W'(by_r & MASK);
      end
      skrp_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_x_nxt      = res_x_r;
          out_y_nxt      = res_y_r;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skrp_pkg::ST_INIT;
      bank_r      <= 1'b0;
      count_r     <= CNT_ONE;
      found_r     <= 1'b0;
      n_done_r    <= 1'b0;
      trim_r      <= 1'b0;
      acc_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      count_r     <= count_nxt;
      found_r     <= found_nxt;
      n_done_r    <= n_done_nxt;
      trim_r      <= trim_nxt;
      acc_v_r     <= acc_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rw_r         <= rw_nxt;
    rh_r         <= rh_nxt;
    start_r      <= start_nxt;
    idx_r        <= idx_nxt;
    t_r          <= t_nxt;
    remain_r     <= remain_nxt;
    cand_x_r     <= cand_x_nxt;
    cand_w_r     <= cand_w_nxt;
    best_r       <= best_nxt;
    best_top_r   <= best_top_nxt;
    best_w_r     <= best_w_nxt;
    bx_r         <= bx_nxt;
    by_r         <= by_nxt;
    j_r          <= j_nxt;
    wr_ptr_r     <= wr_ptr_nxt;
    acc_x_r      <= acc_x_nxt;
    acc_y_r      <= acc_y_nxt;
    acc_w_r      <= acc_w_nxt;
    res_status_r <= res_status_nxt;
    res_x_r      <= res_x_nxt;
    res_y_r      <= res_y_nxt;
    out_status_r <= out_status_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
  end

  assign in_ch.ready   = (state_r == skrp_pkg::ST_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.pos_x  = out_x_r;
  assign out_ch.pos_y  = out_y_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) && (count_r <= CNT_MAX))
    else $error("segment count out of range");

  a_rebuild_has_fit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == skrp_pkg::ST_BRD) |-> (found_r && (best_r < count_r)))
    else $error("rebuild started without a placement");

  a_write_behind_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == skrp_pkg::ST_BEV) |-> (wr_ptr_r <= j_r))
    else $error("rebuild write pointer ran ahead of the read pointer");

  a_bank_swap_on_place: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == skrp_pkg::ST_BEND) |=> (bank_r != $past(bank_r)))
    else $error("table bank did not swap after a placement");

endmodule : skyline_rect_packer

`default_nettype wire
